/* rtl/bm25tw_pkg.sv */
// shared widths, register indexes, reset values and types of the bm25 term weight core
`default_nettype none

package bm25tw_pkg;

  // request fields
  localparam int unsigned QTF_W = 8;
  localparam int unsigned TF_W  = 16;
  localparam int unsigned LEN_W = 20;
  localparam int unsigned DF_W  = 24;

  // placement in the request tdata, lowest field first
  localparam int unsigned QTF_LSB    = 0;
  localparam int unsigned TF_LSB     = QTF_LSB + QTF_W;
  localparam int unsigned LEN_LSB    = TF_LSB + TF_W;
  localparam int unsigned DF_LSB     = LEN_LSB + LEN_W;
  localparam int unsigned IN_TDATA_W = 72;

  // result fields
  localparam int unsigned WEIGHT_W = 32;

  // configuration registers
  localparam int unsigned N_W        = 24;
  localparam int unsigned AVG_W      = 32;
  localparam int unsigned B_W        = 13;
  localparam int unsigned K_W        = 16;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_DOC_COUNT   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_AVG_DOC_LEN = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LEN_NORM_B  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TF_SAT_K1   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_QTF_SAT_K3  = 3'd4;

  localparam logic [N_W-1:0]   RST_DOC_COUNT   = 24'd1;
  localparam logic [AVG_W-1:0] RST_AVG_DOC_LEN = 32'd256;
  localparam logic [B_W-1:0]   RST_LEN_NORM_B  = 13'd3072;
  localparam logic [K_W-1:0]   RST_TF_SAT_K1   = 16'd6144;
  localparam logic [K_W-1:0]   RST_QTF_SAT_K3  = 16'd6144;

  // 1.0 in Q1.12 / Q4.12
  localparam logic [B_W-1:0] ONE_Q12 = 13'd4096;

  // log2 unit: operand below 2^25, result Q20
  localparam int unsigned LOG_XW   = 25;
  localparam int unsigned LOG_FRAC = 20;
  localparam int unsigned LOG_EW   = 5;
  localparam int unsigned LOG_W    = LOG_EW + LOG_FRAC;
  localparam int unsigned LOG_LAT  = 1 + LOG_FRAC;

  // datapath widths
  localparam int unsigned T_W    = 45;  // length normalization term
  localparam int unsigned KN_W   = 61;  // k1 * t
  localparam int unsigned KD_W   = 40;  // avg << 8
  localparam int unsigned KQ_W   = 49;  // K in Q16
  localparam int unsigned FN_W   = 33;  // (k1 + 1) * tf
  localparam int unsigned FNUM_W = 61;
  localparam int unsigned FDEN_W = 50;
  localparam int unsigned FQ_W   = 29;  // Ftf and Fqtf quotients, Q24
  localparam int unsigned QN_W   = 25;  // (k3 + 1) * qtf
  localparam int unsigned QD_W   = 21;  // k3 + qtf
  localparam int unsigned P_W    = 34;
  localparam int unsigned PROD_W = 59;

  localparam int unsigned OUT_FRAC_BITS_DEF = 16;
  localparam int unsigned MAG_SHIFT_BASE    = 44;

  // flags that travel beside the arithmetic
  typedef struct packed {
    logic vld;
    logic inv;
    logic tf_zero;
    logic qtf_zero;
  } side_t;

  // one finished result
  typedef struct packed {
    logic [WEIGHT_W-1:0] weight;
    logic                inv;
  } res_t;

endpackage

`default_nettype wire

/* rtl/bm25tw_dly.sv */
// enabled delay line that keeps operands aligned with the pipeline
`default_nettype none

module bm25tw_dly #(
  parameter int unsigned W = 1,
  parameter int unsigned D = 1
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         en,
  input  logic [W-1:0] d,
  output logic [W-1:0] q
);

  logic [W-1:0] sr_r [0:D-1];

  // shift one place per advancing cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < D; i++) sr_r[i] <= '0;
    end else if (en) begin
      sr_r[0] <= d;
      for (int i = 1; i < D; i++) sr_r[i] <= sr_r[i-1];
    end
  end

  assign q = sr_r[D-1];

endmodule

`default_nettype wire

/* rtl/bm25tw_log2.sv */
// pipelined base-2 logarithm, one fraction bit per stage by repeated squaring
`default_nettype none

module bm25tw_log2 #(
  parameter int unsigned XW = bm25tw_pkg::LOG_XW,
  parameter int unsigned FW = bm25tw_pkg::LOG_FRAC
) (
  input  logic                       clk,
  input  logic                       en,
  input  logic [XW-1:0]              x,
  output logic [$clog2(XW)+FW-1:0]   y
);

  localparam int unsigned EW = $clog2(XW);
  localparam int unsigned MW = 31;            // mantissa Q1.30
  localparam int unsigned SW = $clog2(MW);

  logic [EW-1:0] e_nxt;
  logic [MW-1:0] m_nxt;

  logic [EW-1:0] e_r [0:FW];
  logic [FW-1:0] f_r [0:FW];
  logic [MW-1:0] m_r [0:FW-1];

  // leading one position and normalization to [1,2)
  always_comb begin
    e_nxt = '0;
    for (int i = 0; i < XW; i++) begin
      if (x[i]) e_nxt = EW'(i);
    end
    m_nxt = MW'(x) << (SW'(MW - 1) - SW'(e_nxt));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      e_r[0] <= e_nxt;
      m_r[0] <= m_nxt;
      f_r[0] <= '0;
    end
  end

  // squaring stages
  genvar g;
  generate
    for (g = 0; g < FW; g++) begin : g_sq
      logic [2*MW-1:0] sq;
      logic [MW:0]     ms;
      assign sq = m_r[g] * m_r[g];
      assign ms = sq[2*MW-1 -: MW+1];

      always_ff @(posedge clk) begin
        if (en) begin
          e_r[g+1] <= e_r[g];
          f_r[g+1] <= {f_r[g][FW-2:0], ms[MW]};
        end
      end

      if (g < FW - 1) begin : g_m
        always_ff @(posedge clk) begin
          if (en) m_r[g+1] <= ms[MW] ? ms[MW:1] : ms[MW-1:0];
        end
      end
    end
  endgenerate

  assign y = {e_r[FW], f_r[FW]};

endmodule

`default_nettype wire

/* rtl/bm25tw_div.sv */
// pipelined restoring divider, one quotient bit per stage, quotient known below 2^QW
`default_nettype none

module bm25tw_div #(
  parameter int unsigned DW = 16,
  parameter int unsigned QW = 16
) (
  input  logic             clk,
  input  logic             en,
  input  logic [DW+QW-1:0] num,
  input  logic [DW-1:0]    den,
  output logic [QW-1:0]    quo
);

  // upper DW bits hold the partial remainder, lower QW bits numerator then quotient
  logic [DW+QW-1:0] acc_r [1:QW];
  logic [DW-1:0]    den_r [1:QW-1];

  genvar g;
  generate
    for (g = 0; g < QW; g++) begin : g_step
      logic [DW+QW-1:0] cur;
      logic [DW-1:0]    dcur;
      logic [DW:0]      cand;
      logic [DW:0]      diff;
      logic             qb;

      if (g == 0) begin : g_in
        assign cur  = num;
        assign dcur = den;
      end else begin : g_mid
        assign cur  = acc_r[g];
        assign dcur = den_r[g];
      end

      // trial subtract
      assign cand = cur[DW+QW-1:QW-1];
      assign diff = cand - {1'b0, dcur};
      assign qb   = (cand >= {1'b0, dcur});

      always_ff @(posedge clk) begin
        if (en) acc_r[g+1] <= {(qb ? diff[DW-1:0] : cand[DW-1:0]), cur[QW-2:0], qb};
      end

      if (g < QW - 1) begin : g_den
        always_ff @(posedge clk) begin
          if (en) den_r[g+1] <= dcur;
        end
      end
    end
  endgenerate

  assign quo = acc_r[QW][QW-1:0];

endmodule

`default_nettype wire

/* rtl/bm25_term_weight_core.sv */
// throughput: one request per cycle while the output buffer has room; depth is set by the 49-step divider for K
//   followed by the 29-step divider for Ftf, with the log2 units running beside them
// a two-entry output buffer keeps requests flowing while a result waits
// reset: synchronous active low, clears valid bits, output buffer and config to defaults
`default_nettype none

module bm25_term_weight_core #(
  parameter int unsigned OUT_FRAC_BITS = bm25tw_pkg::OUT_FRAC_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // request channel
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  // query_tf, doc_tf, doc_len, doc_freq, zero fill
  input  logic [bm25tw_pkg::IN_TDATA_W-1:0]    in_tdata,
  // result channel
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  // weight
  output logic [bm25tw_pkg::WEIGHT_W-1:0]      out_tdata,
  // invalid
  output logic                                 out_tuser,
  // configuration writes
  input  logic                                 cfg_wr_en,
  input  logic [bm25tw_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [bm25tw_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  localparam int unsigned QTF_W  = bm25tw_pkg::QTF_W;
  localparam int unsigned TF_W   = bm25tw_pkg::TF_W;
  localparam int unsigned LEN_W  = bm25tw_pkg::LEN_W;
  localparam int unsigned DF_W   = bm25tw_pkg::DF_W;
  localparam int unsigned N_W    = bm25tw_pkg::N_W;
  localparam int unsigned AVG_W  = bm25tw_pkg::AVG_W;
  localparam int unsigned B_W    = bm25tw_pkg::B_W;
  localparam int unsigned K_W    = bm25tw_pkg::K_W;
  localparam int unsigned LOG_XW = bm25tw_pkg::LOG_XW;
  localparam int unsigned LOG_W  = bm25tw_pkg::LOG_W;
  localparam int unsigned T_W    = bm25tw_pkg::T_W;
  localparam int unsigned KN_W   = bm25tw_pkg::KN_W;
  localparam int unsigned KD_W   = bm25tw_pkg::KD_W;
  localparam int unsigned KQ_W   = bm25tw_pkg::KQ_W;
  localparam int unsigned FN_W   = bm25tw_pkg::FN_W;
  localparam int unsigned FNUM_W = bm25tw_pkg::FNUM_W;
  localparam int unsigned FDEN_W = bm25tw_pkg::FDEN_W;
  localparam int unsigned FQ_W   = bm25tw_pkg::FQ_W;
  localparam int unsigned QN_W   = bm25tw_pkg::QN_W;
  localparam int unsigned QD_W   = bm25tw_pkg::QD_W;
  localparam int unsigned P_W    = bm25tw_pkg::P_W;
  localparam int unsigned PROD_W = bm25tw_pkg::PROD_W;
  localparam int unsigned WGT_W  = bm25tw_pkg::WEIGHT_W;

  localparam int unsigned SHIFT  = bm25tw_pkg::MAG_SHIFT_BASE - OUT_FRAC_BITS;

  // alignment depths, counted from the operand stage
  localparam int unsigned D_TF   = 1 + KQ_W;
  localparam int unsigned D_Q    = 2 + KQ_W;
  localparam int unsigned D_SIDE = 2 + KQ_W + FQ_W;
  localparam int unsigned D_IDF  = D_SIDE - bm25tw_pkg::LOG_LAT - 1;

  localparam logic [PROD_W-1:0] MAG_LIM = PROD_W'(1) << (WGT_W - 1);

  // configuration registers
  logic [N_W-1:0]   n_r;
  logic [AVG_W-1:0] avg_r;
  logic [B_W-1:0]   b_r;
  logic [K_W-1:0]   k1_r;
  logic [K_W-1:0]   k3_r;

  logic adv;
  logic in_acc;

  // input stage
  logic             va_r;
  logic [QTF_W-1:0] qtf_a_r;
  logic [TF_W-1:0]  tf_a_r;
  logic [LEN_W-1:0] len_a_r;
  logic [DF_W-1:0]  df_a_r;

  // operand stage
  logic              vb_r;
  logic              inv_b_r;
  logic              tfz_b_r;
  logic              qtfz_b_r;
  logic [LOG_XW-1:0] xa_b_r;
  logic [LOG_XW-1:0] xb_b_r;
  logic [T_W-1:0]    t_b_r;
  logic [FN_W-1:0]   fn_b_r;
  logic [QN_W-1:0]   qn_b_r;
  logic [QD_W-1:0]   qd_b_r;
  logic [TF_W-1:0]   tf_b_r;

  logic [B_W-1:0]       b_eff;
  logic [B_W-1:0]       omb;
  logic [B_W+AVG_W-1:0] t1;
  logic [B_W+LEN_W-1:0] t2;
  logic [K_W:0]         k1p;
  logic [K_W:0]         k3p;
  logic [FN_W-1:0]      fn_nxt;
  logic [QN_W-1:0]      qn_nxt;

  // K divider
  logic [KN_W-1:0] kn_c_r;
  logic [KQ_W-1:0] kq;

  // Ftf divider
  logic [TF_W+FN_W-1:0] tffn_d;
  logic [TF_W-1:0]      tf_d;
  logic [FN_W-1:0]      fn_d;
  logic [FDEN_W-1:0]    fden_d_r;
  logic [FNUM_W-1:0]    fnum_d_r;
  logic [FQ_W-1:0]      ftf_q;

  // Fqtf divider
  logic [QN_W+QD_W-1:0] qnd_d;
  logic [QN_W-1:0]      qn_d;
  logic [QD_W-1:0]      qd_d;
  logic [FQ_W-1:0]      fqtf_q;

  // idf
  logic [LOG_W-1:0] la;
  logic [LOG_W-1:0] lb;
  logic             idf_neg_r;
  logic [LOG_W-1:0] idf_mag_r;
  logic [LOG_W:0]   idf_d;

  bm25tw_pkg::side_t side_b;
  bm25tw_pkg::side_t side_d;

  // product stages
  logic             ve_r;
  logic             inv_e_r;
  logic             neg_e_r;
  logic [LOG_W-1:0] mag_e_r;
  logic [P_W-1:0]   p_e_r;
  logic [FQ_W-1:0]  ftf_m;
  logic [FQ_W-1:0]  fqtf_m;
  logic [2*FQ_W-1:0] pp;

  logic              vf_r;
  logic              inv_f_r;
  logic              neg_f_r;
  logic [PROD_W-1:0] prod_f_r;

  logic [PROD_W-1:0] mag_g;
  bm25tw_pkg::res_t  res_g;

  // output buffer
  bm25tw_pkg::res_t slot0_r;
  bm25tw_pkg::res_t slot1_r;
  logic [1:0]       cnt_r;
  logic [1:0]       cnt_nxt;
  logic             push;
  logic             pop;

  // configuration write decode
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n_r   <= bm25tw_pkg::RST_DOC_COUNT;
      avg_r <= bm25tw_pkg::RST_AVG_DOC_LEN;
      b_r   <= bm25tw_pkg::RST_LEN_NORM_B;
      k1_r  <= bm25tw_pkg::RST_TF_SAT_K1;
      k3_r  <= bm25tw_pkg::RST_QTF_SAT_K3;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        bm25tw_pkg::REG_DOC_COUNT:   n_r   <= cfg_wdata[N_W-1:0];
        bm25tw_pkg::REG_AVG_DOC_LEN: avg_r <= cfg_wdata[AVG_W-1:0];
        bm25tw_pkg::REG_LEN_NORM_B:  b_r   <= cfg_wdata[B_W-1:0];
        bm25tw_pkg::REG_TF_SAT_K1:   k1_r  <= cfg_wdata[K_W-1:0];
        bm25tw_pkg::REG_QTF_SAT_K3:  k3_r  <= cfg_wdata[K_W-1:0];
        default: ;
      endcase
    end
  end

  // whole pipeline moves while the output buffer has room
  assign adv       = (cnt_r != 2'd2);
  assign in_tready = adv;
  assign in_acc    = in_tvalid & adv;

  // input stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
    end else if (adv) begin
      va_r <= in_acc;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      qtf_a_r <= in_tdata[bm25tw_pkg::QTF_LSB +: QTF_W];
      tf_a_r  <= in_tdata[bm25tw_pkg::TF_LSB  +: TF_W];
      len_a_r <= in_tdata[bm25tw_pkg::LEN_LSB +: LEN_W];
      df_a_r  <= in_tdata[bm25tw_pkg::DF_LSB  +: DF_W];
    end
  end

  // operand stage: idf arguments, length term, numerators, Fqtf denominator and flags
  assign b_eff  = (b_r > bm25tw_pkg::ONE_Q12) ? bm25tw_pkg::ONE_Q12 : b_r;
  assign omb    = bm25tw_pkg::ONE_Q12 - b_eff;
  assign t1     = omb * avg_r;
  assign t2     = b_eff * len_a_r;
  assign k1p    = (K_W+1)'(k1_r) + (K_W+1)'(bm25tw_pkg::ONE_Q12);
  assign k3p    = (K_W+1)'(k3_r) + (K_W+1)'(bm25tw_pkg::ONE_Q12);
  assign fn_nxt = k1p * tf_a_r;
  assign qn_nxt = k3p * qtf_a_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vb_r <= 1'b0;
    end else if (adv) begin
      vb_r <= va_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      inv_b_r  <= (df_a_r > n_r) || (avg_r == '0);
      tfz_b_r  <= (tf_a_r == '0);
      qtfz_b_r <= (qtf_a_r == '0);
      xa_b_r   <= {n_r, 1'b0} - {df_a_r, 1'b0} + LOG_XW'(1);
      xb_b_r   <= {df_a_r, 1'b1};
      t_b_r    <= T_W'(t1) + T_W'({t2, 8'b0});
      fn_b_r   <= fn_nxt;
      qn_b_r   <= qn_nxt;
      qd_b_r   <= QD_W'(k3_r) + QD_W'({qtf_a_r, 12'b0});
      tf_b_r   <= tf_a_r;
    end
  end

  // K numerator
  always_ff @(posedge clk) begin
    if (adv) kn_c_r <= k1_r * t_b_r;
  end

  bm25tw_div #(.DW(KD_W), .QW(KQ_W)) u_div_k (
    .clk (clk),
    .en  (adv),
    .num ((KD_W+KQ_W)'(kn_c_r)),
    .den ({avg_r, 8'b0}),
    .quo (kq)
  );

  bm25tw_dly #(.W(TF_W+FN_W), .D(D_TF)) u_dly_tf (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (adv),
    .d     ({tf_b_r, fn_b_r}),
    .q     (tffn_d)
  );
  assign tf_d = tffn_d[TF_W+FN_W-1:FN_W];
  assign fn_d = tffn_d[FN_W-1:0];

  // Ftf operands
  always_ff @(posedge clk) begin
    if (adv) begin
      fden_d_r <= FDEN_W'(kq) + FDEN_W'({tf_d, 16'b0});
      fnum_d_r <= FNUM_W'({fn_d, 28'b0});
    end
  end

  bm25tw_div #(.DW(FDEN_W), .QW(FQ_W)) u_div_ftf (
    .clk (clk),
    .en  (adv),
    .num ((FDEN_W+FQ_W)'(fnum_d_r)),
    .den (fden_d_r),
    .quo (ftf_q)
  );

  // Fqtf runs beside Ftf
  bm25tw_dly #(.W(QN_W+QD_W), .D(D_Q)) u_dly_q (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (adv),
    .d     ({qn_b_r, qd_b_r}),
    .q     (qnd_d)
  );
  assign qn_d = qnd_d[QN_W+QD_W-1:QD_W];
  assign qd_d = qnd_d[QD_W-1:0];

  bm25tw_div #(.DW(QD_W), .QW(FQ_W)) u_div_fqtf (
    .clk (clk),
    .en  (adv),
    .num ((QD_W+FQ_W)'({qn_d, 24'b0})),
    .den (qd_d),
    .quo (fqtf_q)
  );

  // idf = log2(2N - 2df + 1) - log2(2df + 1)
  bm25tw_log2 #(.XW(LOG_XW), .FW(bm25tw_pkg::LOG_FRAC)) u_log_a (
    .clk (clk),
    .en  (adv),
    .x   (xa_b_r),
    .y   (la)
  );

  bm25tw_log2 #(.XW(LOG_XW), .FW(bm25tw_pkg::LOG_FRAC)) u_log_b (
    .clk (clk),
    .en  (adv),
    .x   (xb_b_r),
    .y   (lb)
  );

  always_ff @(posedge clk) begin
    if (adv) begin
      idf_neg_r <= (lb > la);
      idf_mag_r <= (lb > la) ? (lb - la) : (la - lb);
    end
  end

  bm25tw_dly #(.W(LOG_W+1), .D(D_IDF)) u_dly_idf (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (adv),
    .d     ({idf_neg_r, idf_mag_r}),
    .q     (idf_d)
  );

  // valid and flags beside the arithmetic
  assign side_b = '{vld: vb_r, inv: inv_b_r, tf_zero: tfz_b_r, qtf_zero: qtfz_b_r};

  bm25tw_dly #(.W($bits(bm25tw_pkg::side_t)), .D(D_SIDE)) u_dly_side (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (adv),
    .d     (side_b),
    .q     (side_d)
  );

  // P = Ftf * Fqtf in Q24
  assign ftf_m  = side_d.tf_zero  ? '0 : ftf_q;
  assign fqtf_m = side_d.qtf_zero ? '0 : fqtf_q;
  assign pp     = ftf_m * fqtf_m;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ve_r <= 1'b0;
    end else if (adv) begin
      ve_r <= side_d.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      inv_e_r <= side_d.inv;
      neg_e_r <= idf_d[LOG_W];
      mag_e_r <= idf_d[LOG_W-1:0];
      p_e_r   <= pp[2*FQ_W-1:24];
    end
  end

  // |idf| * P
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vf_r <= 1'b0;
    end else if (adv) begin
      vf_r <= ve_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      inv_f_r  <= inv_e_r;
      neg_f_r  <= neg_e_r;
      prod_f_r <= mag_e_r * p_e_r;
    end
  end

  // scale, sign and saturate; invalid results give a zero weight
  assign mag_g = prod_f_r >> SHIFT;

  always_comb begin
    res_g.inv = inv_f_r;
    if (inv_f_r) begin
      res_g.weight = '0;
    end else if (neg_f_r) begin
      res_g.weight = (mag_g >= MAG_LIM) ? {1'b1, {(WGT_W-1){1'b0}}}
                                        : WGT_W'(0) - mag_g[WGT_W-1:0];
    end else begin
      res_g.weight = (mag_g >= MAG_LIM) ? {1'b0, {(WGT_W-1){1'b1}}}
                                        : mag_g[WGT_W-1:0];
    end
  end

  // two-entry output buffer
  assign push = vf_r & adv;
  assign pop  = (cnt_r != 2'd0) & out_tready;

  always_comb begin
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push && ((cnt_r == 2'd0) || ((cnt_r == 2'd1) && pop))) begin
      slot0_r <= res_g;
    end else if ((cnt_r == 2'd2) && pop) begin
      slot0_r <= slot1_r;
    end
    if (push && (cnt_r == 2'd1) && !pop) begin
      slot1_r <= res_g;
    end
  end

  assign out_tvalid = (cnt_r != 2'd0);
  assign out_tdata  = slot0_r.weight;
  assign out_tuser  = slot0_r.inv;

  // checks
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != 2'd3)
    else $error("output buffer count out of range");

  a_inv_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser) |-> (out_tdata == '0))
    else $error("invalid result carries a nonzero weight");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (rst_n && !adv) |=> ($stable(vf_r) && $stable(ve_r)))
    else $error("pipeline moved while stalled");

  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'd2) |-> !push)
    else $error("result pushed into a full output buffer");

endmodule

`default_nettype wire
